>>> design/gpd_pkg.sv
package gpd_pkg;

  localparam int CNT_W  = 4;
  localparam int OP_W   = 2;
  localparam int IDX_W  = 3;
  localparam int DIST_W = 7;

  localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

  localparam int REG_COUNT_A = 0;
  localparam int REG_COUNT_B = 1;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic start;
    logic rd;
    logic eval;
    logic perm;
  } gpd_cmd_t;

  typedef struct packed {
    logic m_zero;
    logic last_cell;
    logic has_next;
  } gpd_sts_t;

endpackage

>>> design/gpd_if.sv
interface gpd_in_if;
  logic                        valid;
  logic                        ready;
  logic [gpd_pkg::OP_W-1:0]    operation;
  logic [gpd_pkg::IDX_W-1:0]   row;
  logic [gpd_pkg::IDX_W-1:0]   col;
  logic                        edge_req;

  modport source (output valid, output operation, output row, output col, output edge_req,
                  input ready);
  modport sink   (input valid, input operation, input row, input col, input edge_req,
                  output ready);
endinterface

interface gpd_out_if;
  logic                        valid;
  logic                        ready;
  logic [gpd_pkg::DIST_W-1:0]  distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

>>> design/gpd_ctrl.sv
module gpd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_op_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  gpd_pkg::gpd_sts_t sts_i,
  output gpd_pkg::gpd_cmd_t cmd_o
);
  import gpd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_PERM = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       acc;

  // a compute waits until the previous result has been taken
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || in_op_i != OP_COMPUTE);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          cmd_o.wr_a  = (in_op_i == OP_WRITE_A);
          cmd_o.wr_b  = (in_op_i == OP_WRITE_B);
          cmd_o.start = (in_op_i == OP_COMPUTE);
          if (in_op_i == OP_COMPUTE) state_d = sts_i.m_zero ? S_PERM : S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.last_cell ? S_PERM : S_READ;
      end
      S_PERM: begin
        cmd_o.perm = 1'b1;
        if (sts_i.has_next) begin
          state_d = S_READ;
        end else begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

>>> design/gpd_datapath.sv
module gpd_datapath #(
  parameter int MAXV = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [gpd_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic [gpd_pkg::IDX_W-1:0]    row_i,
  input  logic [gpd_pkg::IDX_W-1:0]    col_i,
  input  logic                         edge_i,
  input  gpd_pkg::gpd_cmd_t            cmd_i,
  output gpd_pkg::gpd_sts_t            sts_o,
  output logic [gpd_pkg::DIST_W-1:0]   distance_o
);
  import gpd_pkg::*;

  localparam int CELLS = MAXV * MAXV;
  localparam int VW    = (MAXV > 1) ? $clog2(MAXV) : 1;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [CNT_W-1:0] cnt_a_q, cnt_b_q;
  logic [CNT_W-1:0] na, nb, n, m;

  logic             mem_a [CELLS];
  logic             mem_b [CELLS];
  logic [CELLS-1:0] vld_a_q, vld_b_q;
  logic             bit_a_q, bit_b_q;

  logic [VW-1:0]    perm_q [MAXV];
  logic [VW-1:0]    perm_nx [MAXV];
  logic [VW-1:0]    q [MAXV];
  logic [VW-1:0]    piv, piv_m1, sw;
  logic             found;

  logic [VW-1:0]    ci_q, cj_q;
  logic [DIST_W-1:0] score_q, best_q, dist_q, best_min, base;
  logic [AW-1:0]    wr_addr, rd_a_addr, rd_b_addr;
  logic             wr_ok, shared, cell_bit, last_j;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == 1'(REG_COUNT_A)) cnt_a_q <= cfg_data_i;
      else                              cnt_b_q <= cfg_data_i;
    end
  end

  assign na = (cnt_a_q > CNT_W'(MAXV)) ? CNT_W'(MAXV) : cnt_a_q;
  assign nb = (cnt_b_q > CNT_W'(MAXV)) ? CNT_W'(MAXV) : cnt_b_q;
  assign n  = (na <= nb) ? na : nb;
  assign m  = (na <= nb) ? nb : na;
  assign base = DIST_W'(m - n);

  // matrix stores, cleared at reset through the valid bits
  assign wr_ok   = (int'(row_i) < MAXV) && (int'(col_i) < MAXV);
  assign wr_addr = AW'(int'(row_i) * MAXV + int'(col_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a && wr_ok) mem_a[wr_addr] <= edge_i;
    if (cmd_i.wr_b && wr_ok) mem_b[wr_addr] <= edge_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= '0;
      vld_b_q <= '0;
    end else begin
      if (cmd_i.wr_a && wr_ok) vld_a_q[wr_addr] <= 1'b1;
      if (cmd_i.wr_b && wr_ok) vld_b_q[wr_addr] <= 1'b1;
    end
  end

  assign rd_a_addr = AW'(int'(perm_q[ci_q]) * MAXV + int'(perm_q[cj_q]));
  assign rd_b_addr = AW'(int'(ci_q) * MAXV + int'(cj_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      bit_a_q <= vld_a_q[rd_a_addr] ? mem_a[rd_a_addr] : 1'b0;
      bit_b_q <= vld_b_q[rd_b_addr] ? mem_b[rd_b_addr] : 1'b0;
    end
  end

  // next ordering in lexicographic order
  always_comb begin
    piv   = '0;
    found = 1'b0;
    for (int k = 1; k < MAXV; k++) begin
      if (k < int'(na) && perm_q[k-1] < perm_q[k]) begin
        piv   = VW'(k);
        found = 1'b1;
      end
    end
    piv_m1 = piv - VW'(1);
    sw     = '0;
    for (int k = 0; k < MAXV; k++) begin
      if (found && k < int'(na) && k >= int'(piv) && perm_q[k] > perm_q[piv_m1]) sw = VW'(k);
    end
    q = perm_q;
    q[piv_m1] = perm_q[sw];
    q[sw]     = perm_q[piv_m1];
    perm_nx = q;
    for (int k = 0; k < MAXV; k++) begin
      if (k >= int'(piv) && k < int'(na)) perm_nx[k] = q[VW'(int'(piv) + int'(na) - 1 - k)];
    end
  end

  assign shared   = (CNT_W'(ci_q) < n) && (CNT_W'(cj_q) < n);
  assign cell_bit = shared ? (bit_a_q ^ bit_b_q) : ((na <= nb) ? bit_b_q : bit_a_q);
  assign last_j   = (CNT_W'(cj_q) == m - CNT_W'(1));
  assign best_min = (score_q < best_q) ? score_q : best_q;

  assign sts_o.m_zero    = (m == '0);
  assign sts_o.last_cell = last_j && (CNT_W'(ci_q) == m - CNT_W'(1));
  assign sts_o.has_next  = found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAXV; k++) perm_q[k] <= VW'(k);
      ci_q    <= '0;
      cj_q    <= '0;
      score_q <= '0;
      best_q  <= '0;
    end else if (cmd_i.start) begin
      for (int k = 0; k < MAXV; k++) perm_q[k] <= VW'(k);
      ci_q    <= '0;
      cj_q    <= '0;
      score_q <= base;
      best_q  <= '1;
    end else if (cmd_i.eval) begin
      score_q <= score_q + DIST_W'(cell_bit);
      if (last_j) begin
        cj_q <= '0;
        ci_q <= ci_q + VW'(1);
      end else begin
        cj_q <= cj_q + VW'(1);
      end
    end else if (cmd_i.perm) begin
      best_q  <= best_min;
      ci_q    <= '0;
      cj_q    <= '0;
      score_q <= base;
      if (found) perm_q <= perm_nx;
      else for (int k = 0; k < MAXV; k++) perm_q[k] <= VW'(k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.perm && !found) dist_q <= best_min;
  end

  assign distance_o = dist_q;
endmodule

>>> design/graph_permutation_distance.sv
// graph permutation distance
// in_i carries one item per handshake: operation 0 or 1 writes one cell (row, col,
// edge_req) of the first or second adjacency matrix, operation 2 starts a compute,
// operation 3 is dropped. cfg_we_i with cfg_idx_i 0 or 1 sets count_a or count_b.
// Cell writes are taken one per cycle while no compute is running and give no
// item on out_o. A compute walks every ordering of the first graph's count_a
// vertices; each ordering costs m*m cell reads, where m is the larger count, each
// one registered read of both matrix stores followed by one score update, and
// then the ordering is advanced. out_o.valid rises once the last ordering has
// been advanced.
// The distance is held in an output register until out_o.ready; write items are
// still accepted while it waits, but a further compute is held off until it has
// been taken.
// Reset clears both matrices (per-cell valid bits), the counts and out_o.valid; the distance register is not reset.
module graph_permutation_distance #(
  parameter int MAX_VERTICES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [gpd_pkg::CNT_W-1:0]   cfg_data_i,
  gpd_in_if.sink                      in_i,
  gpd_out_if.source                   out_o
);
  import gpd_pkg::*;

  gpd_cmd_t cmd;
  gpd_sts_t sts;

  gpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gpd_datapath #(.MAXV(MAX_VERTICES)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .row_i     (in_i.row),
    .col_i     (in_i.col),
    .edge_i    (in_i.edge_req),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .distance_o(out_o.distance)
  );
endmodule

>>> design/gpd_checker.sv
module gpd_checker #(
  parameter int MAXV = 8
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_op_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] distance_i
);
  import gpd_pkg::*;

  localparam int MAX_DIST = MAXV * MAXV + MAXV;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_dist_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(distance_i))
    else $error("distance changed while stalled");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == OP_COMPUTE |=> !out_valid_i)
    else $error("result shown before compute ran");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == OP_COMPUTE |=> !in_ready_i)
    else $error("input taken during compute");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> int'(distance_i) <= MAX_DIST)
    else $error("distance out of range");
endmodule

bind graph_permutation_distance gpd_checker #(.MAXV(MAX_VERTICES)) u_gpd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_op_i    (in_i.operation),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .distance_i (out_o.distance)
);
